/* hw/rtl/dtd_pkg.sv */
// dtd_pkg: shared types and constants for the distance tap detector
// no dependencies; used by dtd_front, dtd_queue, dtd_back and the top level
`default_nettype none

package dtd_pkg;

  // default window depth and its legal range
  localparam int unsigned WINDOW_DEF = 16;
  localparam int unsigned WINDOW_MIN = 4;
  localparam int unsigned WINDOW_MAX = 256;

  // config register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_TAP_LIMIT = 1'b1;

  // config reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd50;
  localparam logic [4:0]  TAP_LIMIT_RST = 5'd5;

  // largest reported tap length
  localparam logic [4:0] TAP_LEN_MAX = 5'd31;

  // one accepted sample as seen by the scan engine
  typedef struct packed {
    logic [31:0] count;
    logic        ready;
  } dtd_desc_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREV,
    ST_CUR,
    ST_RUN
  } dtd_state_e;

endpackage

`default_nettype wire

/* hw/rtl/dtd_ram.sv */
// dtd_ram: generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module dtd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/dtd_front.sv */
// dtd_front: accepts samples, writes the ring-buffer window, counts samples
// and tags each beat as window ready or not; uses dtd_pkg
`default_nettype none

module dtd_front #(
  parameter int unsigned WINDOW = dtd_pkg::WINDOW_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [15:0]               distance_i,
  // window memory write side
  output logic                           wr_en_o,
  output logic      [$clog2(WINDOW)-1:0] wr_addr_o,
  output logic      [15:0]               wr_data_o,
  // oldest entry of the window once full
  output logic      [$clog2(WINDOW)-1:0] head_o,
  // descriptor queue
  output logic                           push_valid_o,
  input  wire logic                      push_ready_i,
  output dtd_pkg::dtd_desc_t             push_desc_o,
  // scan engine finished a full-window beat
  input  wire logic                      scan_done_i
);

  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned FW = $clog2(WINDOW + 1);

  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [31:0]   count_q, count_d;
  logic          pend_q, pend_d;
  logic          accept;
  logic          full_next;

  // the window must stay still while a scan is queued or running
  assign in_ready_o = push_ready_i && !pend_q;
  assign accept     = in_valid_i && in_ready_o;
  assign full_next  = (fill_q >= FW'(WINDOW - 1));

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    count_d  = count_q;
    pend_d   = pend_q;
    if (scan_done_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      wr_ptr_d = (wr_ptr_q == AW'(WINDOW - 1)) ? '0 : wr_ptr_q + AW'(1);
      count_d  = count_q + 32'd1;
      if (!full_next || fill_q != FW'(WINDOW)) begin
        fill_d = (fill_q == FW'(WINDOW)) ? fill_q : fill_q + FW'(1);
      end
      if (full_next) begin
        pend_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      fill_q   <= '0;
      count_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
    end
  end

  assign wr_en_o   = accept;
  assign wr_addr_o = wr_ptr_q;
  assign wr_data_o = distance_i;

  // once full, the next write slot holds the oldest sample
  assign head_o = wr_ptr_q;

  assign push_valid_o      = accept;
  assign push_desc_o.count = count_d;
  assign push_desc_o.ready = full_next;

endmodule

`default_nettype wire

/* hw/rtl/dtd_queue.sv */
// dtd_queue: two-entry descriptor fifo between front and scan engine
// uses dtd_pkg for the descriptor type
`default_nettype none

module dtd_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_valid_i,
  output logic                    push_ready_o,
  input  wire dtd_pkg::dtd_desc_t push_desc_i,
  output logic                    pop_valid_o,
  input  wire logic               pop_ready_i,
  output dtd_pkg::dtd_desc_t      pop_desc_o
);

  dtd_pkg::dtd_desc_t entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_desc_o   = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dtd_back.sv */
// dtd_back: scan engine; walks the window through the memory read port looking
// for a falling edge, a short low run and a rising edge; uses dtd_pkg
`default_nettype none

module dtd_back #(
  parameter int unsigned WINDOW = dtd_pkg::WINDOW_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [15:0]               threshold_i,
  input  wire logic [4:0]                tap_limit_i,
  // descriptor queue
  input  wire logic                      pop_valid_i,
  output logic                           pop_ready_o,
  input  wire dtd_pkg::dtd_desc_t        pop_desc_i,
  // window memory read side
  input  wire logic [$clog2(WINDOW)-1:0] head_i,
  output logic                           rd_en_o,
  output logic      [$clog2(WINDOW)-1:0] rd_addr_o,
  input  wire logic [15:0]               rd_data_i,
  output logic                           scan_done_o,
  // result channel
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [31:0]               sample_count_o,
  output logic                           window_ready_o,
  output logic                           tap_found_o,
  output logic      [31:0]               tap_position_o,
  output logic      [4:0]                tap_len_o
);

  localparam int unsigned AW  = $clog2(WINDOW);
  localparam int unsigned LCW = (AW > 5) ? AW : 5;

  dtd_pkg::dtd_state_e state_q, state_d;

  logic [AW-1:0] i_q, i_d;
  logic [AW-1:0] len_q, len_d;
  logic [15:0]   prev_q, prev_d;
  logic [15:0]   cur_q, cur_d;
  logic [16:0]   level_q, level_d;
  logic [31:0]   cnt_q, cnt_d;

  logic          out_valid_q;
  logic [31:0]   out_cnt_q;
  logic          out_rdy_q, out_found_q;
  logic [31:0]   out_pos_q;
  logic [4:0]    out_len_q;

  logic          out_free;
  logic [AW-1:0] rd_k;
  logic [AW:0]   addr_sum;
  logic [16:0]   level_now;
  logic [AW:0]   run_end;
  logic          last_i;
  logic          run_more;
  logic [LCW-1:0] len_ext;
  logic          fin, fin_rdy, fin_found;
  logic [31:0]   fin_cnt;

  assign out_free  = !out_valid_q || out_ready_i;
  assign level_now = {1'b0, rd_data_i} + {1'b0, threshold_i};
  assign run_end   = {1'b0, i_q} + {1'b0, len_q};
  assign last_i    = (i_q == AW'(WINDOW - 3));
  assign len_ext   = LCW'(len_q);
  // keep counting while the level stays low, within the limit and the window
  assign run_more  = (len_ext <= LCW'(tap_limit_i)) &&
                     (run_end < (AW + 1)'(WINDOW - 1)) &&
                     ({1'b0, rd_data_i} <= level_q);

  // window position to ring-buffer address
  assign addr_sum  = {1'b0, head_i} + {1'b0, rd_k};
  assign rd_addr_o = (addr_sum >= (AW + 1)'(WINDOW)) ?
                     AW'(addr_sum - (AW + 1)'(WINDOW)) : addr_sum[AW-1:0];

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    len_d       = len_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    level_d     = level_q;
    cnt_d       = cnt_q;
    rd_en_o     = 1'b0;
    rd_k        = '0;
    pop_ready_o = 1'b0;
    fin         = 1'b0;
    fin_rdy     = 1'b1;
    fin_found   = 1'b0;
    fin_cnt     = cnt_q;
    unique case (state_q)
      dtd_pkg::ST_IDLE: begin
        pop_ready_o = out_free;
        if (pop_valid_i && out_free) begin
          if (pop_desc_i.ready) begin
            cnt_d   = pop_desc_i.count;
            i_d     = AW'(1);
            rd_en_o = 1'b1;
            rd_k    = '0;
            state_d = dtd_pkg::ST_PREV;
          end else begin
            fin     = 1'b1;
            fin_rdy = 1'b0;
            fin_cnt = pop_desc_i.count;
          end
        end
      end
      dtd_pkg::ST_PREV: begin
        prev_d  = rd_data_i;
        rd_en_o = 1'b1;
        rd_k    = i_q;
        state_d = dtd_pkg::ST_CUR;
      end
      dtd_pkg::ST_CUR: begin
        if ({1'b0, prev_q} > level_now) begin
          // falling edge at i, start measuring the low run
          cur_d   = rd_data_i;
          level_d = level_now;
          len_d   = AW'(1);
          rd_en_o = 1'b1;
          rd_k    = i_q + AW'(1);
          state_d = dtd_pkg::ST_RUN;
        end else if (last_i) begin
          fin     = 1'b1;
          state_d = dtd_pkg::ST_IDLE;
        end else begin
          prev_d  = rd_data_i;
          i_d     = i_q + AW'(1);
          rd_en_o = 1'b1;
          rd_k    = i_q + AW'(1);
        end
      end
      dtd_pkg::ST_RUN: begin
        if (run_more) begin
          len_d   = len_q + AW'(1);
          rd_en_o = 1'b1;
          rd_k    = AW'(run_end + (AW + 1)'(1));
        end else if ({1'b0, rd_data_i} > level_q) begin
          fin       = 1'b1;
          fin_found = 1'b1;
          state_d   = dtd_pkg::ST_IDLE;
        end else if (last_i) begin
          fin     = 1'b1;
          state_d = dtd_pkg::ST_IDLE;
        end else begin
          // no rising edge, resume the edge search one step on
          prev_d  = cur_q;
          i_d     = i_q + AW'(1);
          rd_en_o = 1'b1;
          rd_k    = i_q + AW'(1);
          state_d = dtd_pkg::ST_CUR;
        end
      end
      default: state_d = dtd_pkg::ST_IDLE;
    endcase
  end

  assign scan_done_o = fin && fin_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dtd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    len_q   <= len_d;
    prev_q  <= prev_d;
    cur_q   <= cur_d;
    level_q <= level_d;
    cnt_q   <= cnt_d;
    if (fin) begin
      out_cnt_q   <= fin_cnt;
      out_rdy_q   <= fin_rdy;
      out_found_q <= fin_found;
      out_pos_q   <= fin_found ? cnt_q + 32'(i_q) : 32'd0;
      if (!fin_found) begin
        out_len_q <= 5'd0;
      end else if (len_ext > LCW'(dtd_pkg::TAP_LEN_MAX)) begin
        out_len_q <= dtd_pkg::TAP_LEN_MAX;
      end else begin
        out_len_q <= len_ext[4:0];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_count_o = out_cnt_q;
  assign window_ready_o = out_rdy_q;
  assign tap_found_o    = out_found_q;
  assign tap_position_o = out_pos_q;
  assign tap_len_o      = out_len_q;

endmodule

`default_nettype wire

/* hw/rtl/distance_tap_detector.sv */
// distance_tap_detector: top level; config registers, front, queue, window memory
// and scan engine; depends on dtd_pkg, dtd_ram, dtd_front, dtd_queue, dtd_back
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   input    | in_valid_i/in_ready_o   | distance_i
//   result   | out_valid_o/out_ready_i | sample_count_o, window_ready_o,
//            |                         | tap_found_o, tap_position_o, tap_len_o
//   config   | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// a beat before the window is full passes through the descriptor queue to the result register.
// a full-window beat is scanned one memory read per cycle: one read for the first
// sample, then one per edge-search step and one per low-run sample.
// the front takes no new beat while a full-window scan is queued or running.
// reset clears control state only; the window memory needs no clearing pass.
`default_nettype none

module distance_tap_detector #(
  parameter int unsigned WINDOW = dtd_pkg::WINDOW_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] distance_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] sample_count_o,
  output logic             window_ready_o,
  output logic             tap_found_o,
  output logic      [31:0] tap_position_o,
  output logic      [4:0]  tap_len_o
);

  localparam int unsigned AW = $clog2(WINDOW);

  logic [15:0] threshold_q;
  logic [4:0]  tap_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= dtd_pkg::THRESHOLD_RST;
      tap_limit_q <= dtd_pkg::TAP_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dtd_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        dtd_pkg::CFG_TAP_LIMIT: tap_limit_q <= cfg_data_i[4:0];
        default:                threshold_q <= threshold_q;
      endcase
    end
  end

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [15:0]        wr_data;
  logic [AW-1:0]      head;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [15:0]        rd_data;
  logic               push_valid, push_ready;
  dtd_pkg::dtd_desc_t push_desc;
  logic               pop_valid, pop_ready;
  dtd_pkg::dtd_desc_t pop_desc;
  logic               scan_done;

  dtd_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .distance_i   (distance_i),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .head_o       (head),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_desc_o  (push_desc),
    .scan_done_i  (scan_done)
  );

  dtd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  dtd_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  dtd_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .threshold_i    (threshold_q),
    .tap_limit_i    (tap_limit_q),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_desc_i     (pop_desc),
    .head_i         (head),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .scan_done_o    (scan_done),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_count_o (sample_count_o),
    .window_ready_o (window_ready_o),
    .tap_found_o    (tap_found_o),
    .tap_position_o (tap_position_o),
    .tap_len_o      (tap_len_o)
  );

endmodule

`default_nettype wire
